// ===== rtl/core/stet_pkg.sv =====
// Package for the sorted timed-event table.
// It holds the field widths, the action and status codes, and the shared entry and result types.
// It depends on nothing else.
package stet_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ACT_W  = 2;
    localparam int TIME_W = 32;
    localparam int NAME_W = 16;
    localparam int DUR_W  = 31;
    localparam int STAT_W = 2;
    localparam int RCNT_W = 5;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_REMOVE = 2'd1;
    localparam t_action ACT_QUERY  = 2'd2;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [NAME_W-1:0] ev_name;
        logic [DUR_W-1:0]  ev_dur;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_status           status;
        t_entry            hit;
        logic [RCNT_W-1:0] removed_count;
    } t_result;

    typedef struct packed {
        logic gt;
        logic le;
    } t_cmp_res;

endpackage

// ===== rtl/core/stet_if.sv =====
// Channel interfaces of the sorted timed-event table: the request channel and the result channel.
// Each carries valid, ready and the payload fields; widths come from stet_pkg.
interface stet_in_if;
    logic                                valid;
    logic                                ready;
    logic [stet_pkg::ACT_W-1:0]          action;
    logic signed [stet_pkg::TIME_W-1:0]  event_time;
    logic [stet_pkg::NAME_W-1:0]         event_name;
    logic [stet_pkg::DUR_W-1:0]          event_duration;
    logic signed [stet_pkg::TIME_W-1:0]  window_start;
    logic signed [stet_pkg::TIME_W-1:0]  window_end;

    modport source (output valid, action, event_time, event_name, event_duration,
                    window_start, window_end, input ready);
    modport sink   (input valid, action, event_time, event_name, event_duration,
                    window_start, window_end, output ready);
endinterface

interface stet_out_if;
    logic                                valid;
    logic                                ready;
    logic [stet_pkg::STAT_W-1:0]         status;
    logic signed [stet_pkg::TIME_W-1:0]  hit_time;
    logic [stet_pkg::NAME_W-1:0]         hit_name;
    logic [stet_pkg::DUR_W-1:0]          hit_duration;
    logic [stet_pkg::RCNT_W-1:0]         removed_count;
    logic                                last;

    modport source (output valid, status, hit_time, hit_name, hit_duration, removed_count,
                    last, input ready);
    modport sink   (input valid, status, hit_time, hit_name, hit_duration, removed_count,
                    last, output ready);
endinterface

// ===== rtl/core/stet_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// It holds the event entries of the table; it depends on nothing else.
module stet_ram #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/stet_cmp.sv =====
// Shared signed time comparator of the sorted timed-event table.
// It gives a > b and a <= c; it depends on stet_pkg.
module stet_cmp (
    input  logic signed [stet_pkg::TIME_W-1:0] i_a,
    input  logic signed [stet_pkg::TIME_W-1:0] i_b,
    input  logic signed [stet_pkg::TIME_W-1:0] i_c,
    output stet_pkg::t_cmp_res                 o_res
);
    import stet_pkg::*;

    assign o_res.gt = (i_a > i_b);
    assign o_res.le = (i_a <= i_c);

endmodule

// ===== rtl/core/sorted_time_event_table.sv =====
// Top level of the sorted timed-event table: sequencer, entry memory and shared comparator.
// It depends on stet_pkg, stet_if, stet_ram and stet_cmp.
//
//   Channel    Direction  Handshake            Contents
//   i_item     in         valid / ready        action, event time, name, duration, window
//   o_result   out        valid / ready        status, hit fields, removed count, last
//   i_cfg      in         write enable only    play_length
//
// One request is taken at a time; ready is high only while the sequencer is idle.
// Insert shifts each later entry up by one slot, remove compacts the kept entries, and query
// scans every entry, twice for a wrapped window, one entry per cycle through the single read
// port of the entry memory, as long as a query is not stalled.
// A query stalls on a new hit while a stored hit and the output register both wait on o_result.ready.
// Reset clears the entry count, the sequencer and play_length; entries hold no reset value.
module sorted_time_event_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stet_pkg::DUR_W-1:0] i_cfg_wdata,
    stet_in_if.sink                    i_item,
    stet_out_if.source                 o_result
);
    import stet_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_REM  = 5'b00100,
        S_QRY  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state             r_state,    n_state;
    logic [CNT_W-1:0]   r_cnt,      n_cnt;
    logic [CNT_W-1:0]   r_idx,      n_idx;
    logic [CNT_W-1:0]   r_keep,     n_keep;
    logic               r_pass,     n_pass;
    logic               r_wrap,     n_wrap;
    logic [DUR_W-1:0]   r_play_len, n_play_len;
    t_entry             r_key,      n_key;
    logic [TIME_W-1:0]  r_ws,       n_ws;
    logic [TIME_W-1:0]  r_we,       n_we;
    t_result            r_hold,     n_hold;
    logic               r_hold_v,   n_hold_v;
    t_result            r_out,      n_out;
    logic               r_out_last, n_out_last;
    logic               r_out_v,    n_out_v;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ADDR_W-1:0]  w_raddr;
    t_entry             w_wdata;
    t_entry             w_rdata;
    logic [TIME_W-1:0]  w_cmp_a;
    logic [TIME_W-1:0]  w_cmp_b;
    logic [TIME_W-1:0]  w_cmp_c;
    t_cmp_res           w_cmp;
    logic               w_out_free;
    logic               w_hit;

    stet_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    stet_cmp u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .i_c   (w_cmp_c),
        .o_res (w_cmp)
    );

    assign w_out_free   = !r_out_v || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_keep     = r_keep;
        n_pass     = r_pass;
        n_wrap     = r_wrap;
        n_play_len = i_cfg_we ? i_cfg_wdata : r_play_len;
        n_key      = r_key;
        n_ws       = r_ws;
        n_we       = r_we;
        n_hold     = r_hold;
        n_hold_v   = r_hold_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !o_result.ready;

        w_we    = 1'b0;
        w_waddr = r_idx[ADDR_W-1:0];
        w_wdata = w_rdata;
        w_raddr = r_idx[ADDR_W-1:0];
        w_cmp_a = w_rdata.ev_time;
        w_cmp_b = r_pass ? '1 : r_ws;
        w_cmp_c = (r_wrap && !r_pass) ? {1'b0, r_play_len} : r_we;
        w_hit   = w_cmp.gt && w_cmp.le;

        unique case (r_state)
            S_IDLE: begin
                w_raddr = (i_item.action == ACT_INSERT) ? ADDR_W'(r_cnt - CNT_W'(1)) : '0;
                w_cmp_a = i_item.window_start;
                w_cmp_b = i_item.window_end;
                if (i_item.valid) begin
                    n_key    = '{ev_time: i_item.event_time, ev_name: i_item.event_name,
                                 ev_dur: i_item.event_duration};
                    n_ws     = i_item.window_start;
                    n_we     = i_item.window_end;
                    n_wrap   = w_cmp.gt;
                    n_pass   = 1'b0;
                    n_idx    = '0;
                    n_keep   = '0;
                    n_hold_v = 1'b0;
                    unique case (i_item.action)
                        ACT_INSERT: begin
                            if (r_cnt >= CNT_W'(TABLE_DEPTH)) begin
                                n_hold   = '{status: ST_FULL, hit: '0, removed_count: '0};
                                n_hold_v = 1'b1;
                                n_state  = S_FIN;
                            end else begin
                                n_idx   = r_cnt;
                                n_state = S_INS;
                            end
                        end
                        ACT_REMOVE: begin
                            n_state = S_REM;
                        end
                        ACT_QUERY: begin
                            n_state = S_QRY;
                        end
                        default: begin
                            n_hold   = '{status: ST_OK, hit: '0, removed_count: '0};
                            n_hold_v = 1'b1;
                            n_state  = S_FIN;
                        end
                    endcase
                end
            end
            S_INS: begin
                w_cmp_a = r_key.ev_time;
                w_cmp_b = w_rdata.ev_time;
                w_we    = 1'b1;
                w_waddr = r_idx[ADDR_W-1:0];
                if (r_idx == '0 || w_cmp.gt) begin
                    w_wdata  = r_key;
                    n_cnt    = r_cnt + CNT_W'(1);
                    n_hold   = '{status: ST_OK, hit: '0, removed_count: '0};
                    n_hold_v = 1'b1;
                    n_state  = S_FIN;
                end else begin
                    w_wdata = w_rdata;
                    n_idx   = r_idx - CNT_W'(1);
                    w_raddr = ADDR_W'(r_idx - CNT_W'(2));
                end
            end
            S_REM: begin
                if (r_idx == r_cnt) begin
                    n_cnt    = r_keep;
                    n_hold   = '{status: ST_OK, hit: '0,
                                 removed_count: RCNT_W'(r_cnt - r_keep)};
                    n_hold_v = 1'b1;
                    n_state  = S_FIN;
                end else begin
                    if (w_rdata.ev_name != r_key.ev_name) begin
                        w_we    = 1'b1;
                        w_waddr = r_keep[ADDR_W-1:0];
                        w_wdata = w_rdata;
                        n_keep  = r_keep + CNT_W'(1);
                    end
                    n_idx   = r_idx + CNT_W'(1);
                    w_raddr = ADDR_W'(r_idx + CNT_W'(1));
                end
            end
            S_QRY: begin
                if (r_idx == r_cnt) begin
                    n_state = S_FIN;
                end else if (!w_hit || !r_hold_v || w_out_free) begin
                    if (w_hit) begin
                        if (r_hold_v) begin
                            n_out      = r_hold;
                            n_out_last = 1'b0;
                            n_out_v    = 1'b1;
                        end
                        n_hold   = '{status: ST_OK, hit: w_rdata, removed_count: '0};
                        n_hold_v = 1'b1;
                    end
                    if (r_idx == r_cnt - CNT_W'(1)) begin
                        if (r_wrap && !r_pass) begin
                            n_pass  = 1'b1;
                            n_idx   = '0;
                            w_raddr = '0;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        w_raddr = ADDR_W'(r_idx + CNT_W'(1));
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out      = r_hold_v ? r_hold
                                          : '{status: ST_NOMATCH, hit: '0, removed_count: '0};
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_play_len <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_hold_v   <= n_hold_v;
            r_out_v    <= n_out_v;
            r_play_len <= n_play_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_keep     <= n_keep;
        r_pass     <= n_pass;
        r_wrap     <= n_wrap;
        r_key      <= n_key;
        r_ws       <= n_ws;
        r_we       <= n_we;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_result.valid         = r_out_v;
    assign o_result.status        = r_out.status;
    assign o_result.hit_time      = r_out.hit.ev_time;
    assign o_result.hit_name      = r_out.hit.ev_name;
    assign o_result.hit_duration  = r_out.hit.ev_dur;
    assign o_result.removed_count = r_out.removed_count;
    assign o_result.last          = r_out_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_cnt_only_on_update: assert property (@(posedge i_clk)
        (i_rst_n && r_state != S_INS && r_state != S_REM) |=> $stable(r_cnt))
        else $error("Entry count changed outside an insert or remove.");

    a_accept_busy: assert property (@(posedge i_clk)
        (i_rst_n && i_item.valid && i_item.ready) |=> (r_state != S_IDLE))
        else $error("Sequencer stayed idle after a request transaction.");

    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY) |-> !w_we)
        else $error("Entry memory written during a query.");

    a_nomatch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == ST_NOMATCH) |-> o_result.last)
        else $error("No-match result not marked as the final transaction.");
`endif

endmodule

// ===== bench/stet_checker.sv =====
// Checker for the sorted timed-event table: watches the request, result and register ports.
// It keeps its own copy of the table, predicts every result and compares it field by field.
// It depends on stet_pkg and the channel interfaces in stet_if.
`timescale 1ns / 100ps

module stet_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stet_pkg::DUR_W-1:0] i_cfg_wdata,
    stet_in_if                         i_item,
    stet_out_if                        i_result,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_reply_count,
    output int                         o_full_count
);
    import stet_pkg::*;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_reply;

    t_entry           slots [TABLE_DEPTH];
    int               fill;
    logic [DUR_W-1:0] wrap_length;
    t_reply           replies_due [$];

    function automatic t_reply reply(t_status st, t_entry hit, logic [RCNT_W-1:0] removed,
                                     logic lst);
        reply.res.status        = st;
        reply.res.hit           = hit;
        reply.res.removed_count = removed;
        reply.last              = lst;
    endfunction

    task automatic predict_request();
        logic signed [TIME_W-1:0] t;
        logic signed [TIME_W-1:0] lo;
        logic signed [TIME_W-1:0] hi;
        logic signed [TIME_W-1:0] slot_t;
        logic signed [TIME_W:0]   top_len;
        t_reply                   tail;
        int                       pos;
        int                       keep;
        int                       hits;
        logic                     match;
        case (i_item.action)
            ACT_INSERT: begin
                if (fill >= TABLE_DEPTH) begin
                    replies_due.push_back(reply(ST_FULL, '0, '0, 1'b1));
                    o_full_count++;
                end else begin
                    t   = i_item.event_time;
                    pos = 0;
                    while (pos < fill && $signed(slots[pos].ev_time) < t) pos++;
                    for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
                    slots[pos].ev_time = t;
                    slots[pos].ev_name = i_item.event_name;
                    slots[pos].ev_dur  = i_item.event_duration;
                    fill++;
                    replies_due.push_back(reply(ST_OK, '0, '0, 1'b1));
                end
            end
            ACT_REMOVE: begin
                keep = 0;
                for (int i = 0; i < fill; i++) begin
                    if (slots[i].ev_name != i_item.event_name) begin
                        slots[keep] = slots[i];
                        keep++;
                    end
                end
                replies_due.push_back(reply(ST_OK, '0, RCNT_W'(fill - keep), 1'b1));
                fill = keep;
            end
            ACT_QUERY: begin
                lo      = i_item.window_start;
                hi      = i_item.window_end;
                top_len = {2'b00, wrap_length};
                hits    = 0;
                // A wrapped window is scanned twice: the tail of the sequence, then its head.
                for (int p = 0; p < 2; p++) begin
                    for (int i = 0; i < fill; i++) begin
                        slot_t = slots[i].ev_time;
                        if (lo <= hi) begin
                            match = (p == 0) && slot_t > lo && slot_t <= hi;
                        end else if (p == 0) begin
                            match = slot_t > lo && slot_t <= top_len;
                        end else begin
                            match = slot_t >= 0 && slot_t <= hi;
                        end
                        if (match) begin
                            replies_due.push_back(reply(ST_OK, slots[i], '0, 1'b0));
                            hits++;
                        end
                    end
                end
                if (hits == 0) begin
                    replies_due.push_back(reply(ST_NOMATCH, '0, '0, 1'b1));
                end else begin
                    tail      = replies_due.pop_back();
                    tail.last = 1'b1;
                    replies_due.push_back(tail);
                end
            end
            default: begin
                replies_due.push_back(reply(ST_OK, '0, '0, 1'b1));
            end
        endcase
    endtask

    task automatic compare_field(input string label, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h, got %h", $time, label, want_v, got_v);
            o_fail_count++;
        end
    endtask

    task automatic check_reply();
        t_reply want;
        o_reply_count++;
        if (replies_due.size() == 0) begin
            $display("%0t: result transaction with nothing expected: status %0d time %h name %h",
                     $time, i_result.status, i_result.hit_time, i_result.hit_name);
            o_fail_count++;
        end else begin
            want = replies_due.pop_front();
            compare_field("status", 32'(want.res.status), 32'(i_result.status));
            compare_field("hit_time", want.res.hit.ev_time, i_result.hit_time);
            compare_field("hit_name", 32'(want.res.hit.ev_name), 32'(i_result.hit_name));
            compare_field("hit_duration", 32'(want.res.hit.ev_dur), 32'(i_result.hit_duration));
            compare_field("removed_count", 32'(want.res.removed_count),
                          32'(i_result.removed_count));
            compare_field("last", 32'(want.last), 32'(i_result.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill        = 0;
            wrap_length = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_we) wrap_length = i_cfg_wdata;
            if (i_result.valid && i_result.ready) check_reply();
            if (i_item.valid && i_item.ready) predict_request();
        end
        o_pending = replies_due.size();
    end

endmodule

// ===== bench/tb.sv =====
// Top of the testbench for the sorted timed-event table: clock, reset, stimulus and verdict.
// It drives directed and random transactions under changing flow control and play lengths.
// It depends on stet_pkg, stet_if, the block itself and stet_checker.
`timescale 1ns / 100ps

module tb;
    import stet_pkg::*;

    localparam int      RUN_LIMIT     = 1000000;
    localparam int      SETTLE_CYCLES = 40;
    localparam int      PHASE_ITEMS   = 170;
    localparam t_action ACT_UNUSED    = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [DUR_W-1:0] cfg_wdata;
    logic [DUR_W-1:0] cur_length;
    logic [31:0]      last_time;
    int               send_idle;
    int               recv_idle;
    int               cycles = 0;
    int               fail_count;
    int               pending;
    int               reply_count;
    int               full_count;
    int               n_insert;
    int               n_remove;
    int               n_query;
    int               n_wrapped;
    int               n_unused;

    stet_in_if  item_if ();
    stet_out_if result_if ();

    sorted_time_event_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    stet_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_item        (item_if),
        .i_result      (result_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_reply_count (reply_count),
        .o_full_count  (full_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            result_if.ready = ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(input t_action act, input logic [31:0] t,
                                input logic [NAME_W-1:0] nm, input logic [DUR_W-1:0] dur,
                                input logic [31:0] ws, input logic [31:0] we);
        if ($urandom_range(99) < send_idle) begin
            item_if.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        item_if.valid          = 1'b1;
        item_if.action         = act;
        item_if.event_time     = t;
        item_if.event_name     = nm;
        item_if.event_duration = dur;
        item_if.window_start   = ws;
        item_if.window_end     = we;
        while (!item_if.ready) @(negedge i_clk);
        @(negedge i_clk);
        case (act)
            ACT_INSERT: n_insert++;
            ACT_REMOVE: n_remove++;
            ACT_QUERY: begin
                n_query++;
                if ($signed(ws) > $signed(we)) n_wrapped++;
            end
            default: n_unused++;
        endcase
    endtask

    // Lowers valid and waits until every result has come and the block has gone quiet.
    task automatic settle();
        item_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_length(input logic [DUR_W-1:0] value);
        settle();
        cfg_wdata  = value;
        cfg_we     = 1'b1;
        cur_length = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Times cluster around the play length so that windows catch stored events.
    function automatic logic [31:0] pick_time();
        case ($urandom_range(9))
            0: pick_time = $urandom;
            1: begin
                case ($urandom_range(4))
                    0: pick_time = 32'h8000_0000;
                    1: pick_time = 32'h7FFF_FFFF;
                    2: pick_time = '0;
                    3: pick_time = '1;
                    default: pick_time = {1'b0, cur_length};
                endcase
            end
            2: pick_time = last_time;
            3: pick_time = {1'b0, cur_length} - 32'($urandom_range(3)) * 32'h0000_8000;
            default: pick_time = 32'($urandom_range(32'h0030_0000)) - 32'h0008_0000;
        endcase
    endfunction

    task automatic random_request();
        int unsigned       pick;
        logic [31:0]       t;
        logic [31:0]       ws;
        logic [31:0]       we;
        logic [NAME_W-1:0] nm;
        pick = $urandom_range(99);
        nm   = ($urandom_range(9) < 8) ? NAME_W'($urandom_range(7)) : NAME_W'($urandom);
        if (pick < 46) begin
            t         = pick_time();
            last_time = t;
            send_request(ACT_INSERT, t, nm, DUR_W'($urandom), $urandom, $urandom);
        end else if (pick < 62) begin
            send_request(ACT_REMOVE, $urandom, nm, DUR_W'($urandom), $urandom, $urandom);
        end else if (pick < 97) begin
            ws = pick_time();
            we = ($urandom_range(9) == 0) ? ws : pick_time();
            send_request(ACT_QUERY, $urandom, nm, DUR_W'($urandom), ws, we);
        end else begin
            send_request(ACT_UNUSED, $urandom, nm, DUR_W'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [DUR_W-1:0] lengths [6];
        logic [31:0]      t;
        item_if.valid          = 1'b0;
        item_if.action         = ACT_INSERT;
        item_if.event_time     = '0;
        item_if.event_name     = '0;
        item_if.event_duration = '0;
        item_if.window_start   = '0;
        item_if.window_end     = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        cur_length = '0;
        last_time  = '0;
        i_rst_n    = 1'b0;
        send_idle  = 23;
        recv_idle  = 79;
        n_insert   = 0;
        n_remove   = 0;
        n_query    = 0;
        n_wrapped  = 0;
        n_unused   = 0;
        lengths    = '{31'h7FFF_FFFF, 31'h0020_0000, 31'h0, 31'h0, 31'h0001_8000, 31'h7FFF_FFFF};
        lengths[3] = DUR_W'($urandom);
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_length(31'h0010_0000);
        send_request(ACT_QUERY, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_UNUSED, '1, '1, '1, '1, '1);
        // Every event carries the same name so that one remove later clears the whole table.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (i)
                0: t = 32'h7FFF_FFFF;
                1: t = 32'h8000_0000;
                2: t = '0;
                3: t = '0;
                4: t = 32'hFFFF_0000;
                5: t = 32'h0005_0000;
                default: t = 32'(i - 5) * 32'h0000_8000;
            endcase
            send_request(ACT_INSERT, t, 16'hFFFF, (i == 0) ? 31'h7FFF_FFFF : DUR_W'(i),
                         '0, '0);
        end
        send_request(ACT_INSERT, 32'h0000_1000, 16'h0000, 31'h0000_0000, '0, '0);
        send_request(ACT_QUERY, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(ACT_QUERY, '0, '0, '0, 32'h0002_0000, 32'h0000_8000);
        send_request(ACT_QUERY, '0, '0, '0, 32'h0000_8000, 32'h0000_8000);
        send_request(ACT_REMOVE, '0, 16'h0000, '0, '0, '0);
        send_request(ACT_REMOVE, '0, 16'hFFFF, '0, '0, '0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 23 : (phase == 1) ? 79 : 0;
            recv_idle = (phase == 0) ? 79 : (phase == 1) ? 23 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 0 || n == 120) set_length(lengths[2 * phase + (n == 120)]);
                if (phase == 0 && n == 60) settle();
                random_request();
            end
        end
        settle();

        $display("Run covered %0d requests: %0d inserts, %0d removes, %0d queries (%0d wrapped),",
                 n_insert + n_remove + n_query + n_unused, n_insert, n_remove, n_query, n_wrapped);
        $display("%0d with the unused code; %0d results came back, %0d inserts hit a full table.",
                 n_unused, reply_count, full_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
